@@ design/bar_pkg.sv @@
// Package for the button auto-repeat block: word types, register indexes and reset values.
// No dependencies; used by button_autorepeat_accel.
package bar_pkg;

	localparam int MASK_W  = 32;
	localparam int COUNT_W = 16;
	localparam int IVAL_W  = 8;
	localparam int PAD_W   = 3;
	localparam int CFG_W   = 16;
	localparam int CFG_IDX_W = 3;

	localparam logic MODE_SAMPLE    = 1'b0;
	localparam logic MODE_SET_TIMER = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_INITIAL_DELAY    = 3'd0,
		CFG_SLOW_INTERVAL    = 3'd1,
		CFG_MIDDLE_THRESHOLD = 3'd2,
		CFG_MIDDLE_INTERVAL  = 3'd3,
		CFG_FAST_THRESHOLD   = 3'd4,
		CFG_FAST_INTERVAL    = 3'd5
	} cfg_reg_t;

	localparam logic [COUNT_W-1:0] RST_INITIAL_DELAY    = 16'h0014;
	localparam logic [IVAL_W-1:0]  RST_SLOW_INTERVAL    = 8'h08;
	localparam logic [COUNT_W-1:0] RST_MIDDLE_THRESHOLD = 16'h0028;
	localparam logic [IVAL_W-1:0]  RST_MIDDLE_INTERVAL  = 8'h04;
	localparam logic [COUNT_W-1:0] RST_FAST_THRESHOLD   = 16'h0064;
	localparam logic [IVAL_W-1:0]  RST_FAST_INTERVAL    = 8'h02;

	typedef struct packed {
		logic               mode;
		logic [PAD_W-1:0]   pad;
		logic [MASK_W-1:0]  held_mask;
		logic [MASK_W-1:0]  pressed_mask;
		logic [MASK_W-1:0]  released_mask;
		logic [COUNT_W-1:0] timer_value;
	} in_word_t;

	typedef struct packed {
		logic [MASK_W-1:0] repeat_mask;
		logic [MASK_W-1:0] combined_repeat;
	} out_word_t;

endpackage

@@ design/button_autorepeat_accel.sv @@
// Top level of the per-pad button auto-repeat block with three repeat speeds.
// Depends on bar_pkg for the word types, register indexes and reset values.
//
// Channel   Handshake                Payload        Notes
// in        in_valid / in_ready      in_word        one pad sample or set-timer command
// out       out_valid / out_ready    out_word       one result word per input word
// cfg       cfg_wr_en                cfg_index,     plain write, no read-back
//                                    cfg_wdata
//
// Each word is captured in an input register and then passes to the result register,
// which raises out_valid; one word is taken per cycle while out is not stalled. The
// per-pad counters are updated at the edge where a word moves into the result
// register. A stall on out holds the result register; the input register still fills, and
// in_ready drops only when both registers are full. Reset clears both valid flags and
// restores the configuration registers, the per-pad counters and the frame accumulator.
module button_autorepeat_accel #(
	parameter int NUM_PADS    = 4,
	parameter int BUTTON_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  bar_pkg::in_word_t                   in_word,
	output logic                                out_valid,
	input  logic                                out_ready,
	output bar_pkg::out_word_t                  out_word,
	input  logic                                cfg_wr_en,
	input  logic [bar_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bar_pkg::CFG_W-1:0]           cfg_wdata
);

	localparam int IDX_W = (NUM_PADS > 1) ? $clog2(NUM_PADS) : 1;

	logic [bar_pkg::COUNT_W-1:0] initial_delay_q;
	logic [bar_pkg::IVAL_W-1:0]  slow_interval_q;
	logic [bar_pkg::COUNT_W-1:0] middle_threshold_q;
	logic [bar_pkg::IVAL_W-1:0]  middle_interval_q;
	logic [bar_pkg::COUNT_W-1:0] fast_threshold_q;
	logic [bar_pkg::IVAL_W-1:0]  fast_interval_q;

	logic [bar_pkg::COUNT_W-1:0] repeat_counter_q [NUM_PADS];
	logic [bar_pkg::COUNT_W-1:0] hold_count_q [NUM_PADS];
	logic [bar_pkg::MASK_W-1:0]  frame_acc_q;

	logic              valid_s1;
	bar_pkg::in_word_t word_s1;
	logic              out_valid_q;
	bar_pkg::out_word_t out_word_q;

	logic                        advance;
	logic                        take_in;
	logic [bar_pkg::MASK_W-1:0]  button_mask;
	logic [IDX_W-1:0]            idx;
	logic                        pad_ok;
	logic                        pad_all;
	logic                        is_sample;
	logic                        change;
	logic [bar_pkg::COUNT_W-1:0] cnt_cur;
	logic [bar_pkg::COUNT_W-1:0] hold_cur;
	logic [bar_pkg::COUNT_W-1:0] hold_next;
	logic [bar_pkg::COUNT_W-1:0] cnt_next;
	logic [bar_pkg::MASK_W-1:0]  rep;
	logic [bar_pkg::MASK_W-1:0]  acc_next;
	logic [bar_pkg::MASK_W-1:0]  held_m;
	logic [bar_pkg::MASK_W-1:0]  pressed_m;
	logic [bar_pkg::MASK_W-1:0]  released_m;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign take_in  = in_valid && in_ready;

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	always_comb begin
		for (int i = 0; i < bar_pkg::MASK_W; i++) begin
			button_mask[i] = (i < BUTTON_BITS);
		end
	end

	always_comb begin
		idx        = IDX_W'(word_s1.pad);
		pad_ok     = (32'(word_s1.pad) < NUM_PADS);
		pad_all    = (32'(word_s1.pad) == NUM_PADS);
		is_sample  = (word_s1.mode == bar_pkg::MODE_SAMPLE);
		held_m     = word_s1.held_mask & button_mask;
		pressed_m  = word_s1.pressed_mask & button_mask;
		released_m = word_s1.released_mask & button_mask;
		change     = (pressed_m != '0) || (released_m != '0);
		cnt_cur    = pad_ok ? repeat_counter_q[idx] : '0;
		hold_cur   = pad_ok ? hold_count_q[idx] : '0;
		hold_next  = (hold_cur < fast_threshold_q) ? hold_cur + 1'b1 : hold_cur;
		rep        = '0;
		if (change) begin
			rep       = pressed_m;
			cnt_next  = initial_delay_q;
			hold_next = '0;
		end else if (cnt_cur != '0) begin
			cnt_next = cnt_cur - 1'b1;
		end else begin
			rep = held_m;
			priority if (hold_next >= fast_threshold_q) begin
				cnt_next = bar_pkg::COUNT_W'(fast_interval_q);
			end else if (hold_next >= middle_threshold_q) begin
				cnt_next = bar_pkg::COUNT_W'(middle_interval_q);
			end else begin
				cnt_next = bar_pkg::COUNT_W'(slow_interval_q);
			end
		end
		if (!is_sample || !pad_ok) begin
			rep = '0;
		end
		acc_next = ((word_s1.pad == '0) ? '0 : frame_acc_q) | rep;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			initial_delay_q    <= bar_pkg::RST_INITIAL_DELAY;
			slow_interval_q    <= bar_pkg::RST_SLOW_INTERVAL;
			middle_threshold_q <= bar_pkg::RST_MIDDLE_THRESHOLD;
			middle_interval_q  <= bar_pkg::RST_MIDDLE_INTERVAL;
			fast_threshold_q   <= bar_pkg::RST_FAST_THRESHOLD;
			fast_interval_q    <= bar_pkg::RST_FAST_INTERVAL;
		end else if (cfg_wr_en) begin
			case (bar_pkg::cfg_reg_t'(cfg_index))
				bar_pkg::CFG_INITIAL_DELAY: begin
					initial_delay_q <= cfg_wdata;
				end
				bar_pkg::CFG_SLOW_INTERVAL: begin
					slow_interval_q <= cfg_wdata[bar_pkg::IVAL_W-1:0];
				end
				bar_pkg::CFG_MIDDLE_THRESHOLD: begin
					middle_threshold_q <= cfg_wdata;
				end
				bar_pkg::CFG_MIDDLE_INTERVAL: begin
					middle_interval_q <= cfg_wdata[bar_pkg::IVAL_W-1:0];
				end
				bar_pkg::CFG_FAST_THRESHOLD: begin
					fast_threshold_q <= cfg_wdata;
				end
				bar_pkg::CFG_FAST_INTERVAL: begin
					fast_interval_q <= cfg_wdata[bar_pkg::IVAL_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			word_s1 <= in_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_word_q.repeat_mask     <= rep;
			out_word_q.combined_repeat <= (is_sample && pad_ok) ? acc_next : frame_acc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PADS; i++) begin
				repeat_counter_q[i] <= bar_pkg::RST_INITIAL_DELAY;
				hold_count_q[i]     <= '0;
			end
			frame_acc_q <= '0;
		end else if (advance) begin
			if (!is_sample) begin
				for (int i = 0; i < NUM_PADS; i++) begin
					if (pad_all || (pad_ok && (idx == IDX_W'(i)))) begin
						repeat_counter_q[i] <= word_s1.timer_value;
					end
				end
			end else if (pad_ok) begin
				repeat_counter_q[idx] <= cnt_next;
				hold_count_q[idx]     <= hold_next;
				frame_acc_q           <= acc_next;
			end
		end
	end

endmodule
